[hw/rtl/tsq_pkg.sv]
`default_nettype none

package tsq_pkg;

  localparam int unsigned StackDepth = 128;
  localparam int unsigned WordBits   = 32;

  localparam logic       ACT_PUSH = 1'b0;
  localparam logic       ACT_POP  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic       push;
    logic       xfer_rd;
    logic       xfer_wr;
    logic       pop_rd;
    logic       load_res;
    logic       use_rdata;
    logic [1:0] res_status;
  } cmd_t;

  typedef struct packed {
    logic in_full;
    logic in_empty;
    logic out_empty;
    logic slot_free;
  } sts_t;

endpackage

`default_nettype wire

[hw/rtl/tsq_if.sv]
`default_nettype none

interface tsq_item_if #(
  parameter int unsigned DataW = tsq_pkg::WordBits
);
  logic             valid;
  logic             ready;
  logic             action;
  logic [DataW-1:0] data_in;

  modport src (output valid, output action, output data_in, input ready);
  modport snk (input valid, input action, input data_in, output ready);
endinterface

interface tsq_result_if #(
  parameter int unsigned DataW = tsq_pkg::WordBits
);
  logic             valid;
  logic             ready;
  logic [DataW-1:0] data_out;
  logic [1:0]       status;

  modport src (output valid, output data_out, output status, input ready);
  modport snk (input valid, input data_out, input status, output ready);
endinterface

`default_nettype wire

[hw/rtl/tsq_ctrl.sv]
`default_nettype none

module tsq_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_valid_i,
  input  wire logic          item_action_i,
  input  wire tsq_pkg::sts_t sts_i,
  output logic               item_ready_o,
  output tsq_pkg::cmd_t      cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_XFER,
    S_POP_RD,
    S_POP_WAIT
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign item_ready_o = (state_q == S_IDLE) && sts_i.slot_free;
  assign accept       = item_valid_i && item_ready_o;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (item_action_i == tsq_pkg::ACT_PUSH) begin
            cmd_o.load_res = 1'b1;
            if (sts_i.in_full) begin
              cmd_o.res_status = tsq_pkg::ST_FULL;
            end else begin
              cmd_o.push       = 1'b1;
              cmd_o.res_status = tsq_pkg::ST_OK;
            end
          end else if (!sts_i.out_empty) begin
            cmd_o.pop_rd = 1'b1;
            state_d      = S_POP_WAIT;
          end else if (sts_i.in_empty) begin
            cmd_o.load_res   = 1'b1;
            cmd_o.res_status = tsq_pkg::ST_EMPTY;
          end else begin
            cmd_o.xfer_rd = 1'b1;
            state_d       = S_XFER;
          end
        end
      end
      S_XFER: begin
        cmd_o.xfer_wr = 1'b1;
        if (sts_i.in_empty) begin
          state_d = S_POP_RD;
        end else begin
          cmd_o.xfer_rd = 1'b1;
        end
      end
      S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_d      = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        cmd_o.load_res   = 1'b1;
        cmd_o.use_rdata  = 1'b1;
        cmd_o.res_status = tsq_pkg::ST_OK;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tsq_dpath.sv]
`default_nettype none

module tsq_dpath #(
  parameter int unsigned StackDepth = tsq_pkg::StackDepth,
  parameter int unsigned WordBits   = tsq_pkg::WordBits
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire tsq_pkg::cmd_t       cmd_i,
  input  wire logic [WordBits-1:0] data_in_i,
  input  wire logic                res_ready_i,
  output tsq_pkg::sts_t            sts_o,
  output logic                     res_valid_o,
  output logic [WordBits-1:0]      res_data_o,
  output logic [1:0]               res_status_o
);

  localparam int unsigned AddrW = (StackDepth > 1) ? $clog2(StackDepth) : 1;
  localparam int unsigned CntW  = $clog2(StackDepth + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(StackDepth);
  localparam logic [CntW-1:0] CntOne = CntW'(1);

  logic [WordBits-1:0] in_mem  [StackDepth];
  logic [WordBits-1:0] out_mem [StackDepth];

  logic [CntW-1:0]     in_cnt_q, in_cnt_d;
  logic [CntW-1:0]     out_cnt_q, out_cnt_d;
  logic [CntW-1:0]     in_top, out_top;
  logic [WordBits-1:0] in_rdata_q;
  logic [WordBits-1:0] out_rdata_q;
  logic                res_valid_q, res_valid_d;
  logic [WordBits-1:0] res_data_q;
  logic [1:0]          res_status_q;

  assign in_top  = in_cnt_q - CntOne;
  assign out_top = out_cnt_q - CntOne;

  assign sts_o.in_full   = (in_cnt_q == CntMax);
  assign sts_o.in_empty  = (in_cnt_q == '0);
  assign sts_o.out_empty = (out_cnt_q == '0);
  assign sts_o.slot_free = !res_valid_q || res_ready_i;

  always_comb begin
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    if (cmd_i.push) begin
      in_cnt_d = in_cnt_q + CntOne;
    end else if (cmd_i.xfer_rd) begin
      in_cnt_d = in_top;
    end
    if (cmd_i.xfer_wr) begin
      out_cnt_d = out_cnt_q + CntOne;
    end else if (cmd_i.pop_rd) begin
      out_cnt_d = out_top;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.load_res) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      in_cnt_q    <= in_cnt_d;
      out_cnt_q   <= out_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      in_mem[in_cnt_q[AddrW-1:0]] <= data_in_i;
    end
    if (cmd_i.xfer_rd) begin
      in_rdata_q <= in_mem[in_top[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.xfer_wr) begin
      out_mem[out_cnt_q[AddrW-1:0]] <= in_rdata_q;
    end
    if (cmd_i.pop_rd) begin
      out_rdata_q <= out_mem[out_top[AddrW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_res) begin
      res_data_q   <= cmd_i.use_rdata ? out_rdata_q : '0;
      res_status_q <= cmd_i.res_status;
    end
  end

  assign res_valid_o  = res_valid_q;
  assign res_data_o   = res_data_q;
  assign res_status_o = res_status_q;

endmodule

`default_nettype wire

[hw/rtl/two_stack_queue.sv]
// Push: the result beat follows in the cycle after the accepted beat, also when the input
// stack is full (status FULL). Pop with words on the output stack: the top word is read
// from the output stack RAM into a register, then into the result register. A pop that
// finds the output stack empty first moves the N words of the input stack, one per cycle
// through the input RAM read port. A new beat is taken only between operations. Reset
// (rst_ni, async, active low) empties both stacks at once; the stack RAMs are not cleared.
`default_nettype none

module two_stack_queue #(
  parameter int unsigned StackDepth = tsq_pkg::StackDepth,
  parameter int unsigned WordBits   = tsq_pkg::WordBits
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  tsq_item_if.snk   item_i,
  tsq_result_if.src result_o
);

  tsq_pkg::cmd_t cmd;
  tsq_pkg::sts_t sts;
  logic          item_ready;

  assign item_i.ready = item_ready;

  tsq_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_i.valid),
    .item_action_i (item_i.action),
    .sts_i         (sts),
    .item_ready_o  (item_ready),
    .cmd_o         (cmd)
  );

  tsq_dpath #(
    .StackDepth (StackDepth),
    .WordBits   (WordBits)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .data_in_i    (item_i.data_in),
    .res_ready_i  (result_o.ready),
    .sts_o        (sts),
    .res_valid_o  (result_o.valid),
    .res_data_o   (result_o.data_out),
    .res_status_o (result_o.status)
  );

`ifndef NO_ASSERTIONS
  a_push_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_ready && (item_i.action == tsq_pkg::ACT_PUSH)
    |=> result_o.valid && (result_o.status != tsq_pkg::ST_EMPTY))
    else $error("push beat did not produce a push result");

  a_empty_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_i.valid && item_ready && (item_i.action == tsq_pkg::ACT_POP)
      && sts.in_empty && sts.out_empty
    |=> result_o.valid && (result_o.status == tsq_pkg::ST_EMPTY))
    else $error("pop on empty queue not reported as empty");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && (result_o.status != tsq_pkg::ST_OK) |-> (result_o.data_out == '0))
    else $error("failed operation returned nonzero data");

  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load_res |-> sts.slot_free)
    else $error("result register overwritten while still pending");
`endif

endmodule

`default_nettype wire

[tb/tb_two_stack_queue.sv]
module tb_two_stack_queue;

  localparam int unsigned HoldCycles = 300;

  typedef struct packed {
    logic [tsq_pkg::WordBits-1:0] data;
    logic [1:0]                   status;
  } qresult_t;

  logic clk_i;
  logic rst_ni;

  tsq_item_if   item_if ();
  tsq_result_if result_if ();

  two_stack_queue DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_if),
    .result_o(result_if)
  );

  logic [tsq_pkg::WordBits-1:0] in_words [tsq_pkg::StackDepth];
  logic [tsq_pkg::WordBits-1:0] out_words[tsq_pkg::StackDepth];
  int unsigned                  in_depth;
  int unsigned                  out_depth;

  qresult_t pending_results[$];
  int       mismatch_count;

  bit tx_gaps;
  bit rx_free;
  int burst_left;
  int hold_token;
  int hold_seen;
  int hold_left;
  int run_left;
  bit rx_on;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  function automatic qresult_t predict_result(logic act, logic [tsq_pkg::WordBits-1:0] word);
    qresult_t r;
    r.data   = '0;
    r.status = tsq_pkg::ST_OK;
    if (act == tsq_pkg::ACT_PUSH) begin
      if (in_depth >= tsq_pkg::StackDepth) begin
        r.status = tsq_pkg::ST_FULL;
      end else begin
        in_words[in_depth] = word;
        in_depth++;
      end
    end else begin
      // An empty output stack is refilled from the input stack, reversing the order.
      if (out_depth == 0) begin
        while (in_depth > 0 && out_depth < tsq_pkg::StackDepth) begin
          in_depth--;
          out_words[out_depth] = in_words[in_depth];
          out_depth++;
        end
      end
      if (out_depth == 0) begin
        r.status = tsq_pkg::ST_EMPTY;
      end else begin
        out_depth--;
        r.data = out_words[out_depth];
      end
    end
    return r;
  endfunction

  function automatic logic [tsq_pkg::WordBits-1:0] random_word();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return {1'b1, {(tsq_pkg::WordBits-1){1'b0}}};
      default: return $urandom();
    endcase
  endfunction

  task automatic send_beat(input logic act, input logic [tsq_pkg::WordBits-1:0] word);
    int gap;
    if (tx_gaps && burst_left <= 0) begin
      gap = $urandom_range(1, 8);
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    item_if.valid   <= 1'b1;
    item_if.action  <= act;
    item_if.data_in <= word;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    pending_results.push_back(predict_result(act, word));
    burst_left--;
  endtask

  task automatic note_mismatch(input string what, input qresult_t want, input qresult_t got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s: expected data %h status %0d, got data %h status %0d",
               what, want.data, want.status, got.data, got.status);
    end
  endtask

  always @(posedge clk_i) begin : check_results
    qresult_t got;
    qresult_t want;
    if (rst_ni && result_if.valid && result_if.ready) begin
      got.data   = result_if.data_out;
      got.status = result_if.status;
      if (pending_results.size() == 0) begin
        want = '0;
        note_mismatch("Unexpected result beat", want, got);
      end else begin
        want = pending_results.pop_front();
        if (got.data !== want.data || got.status !== want.status) begin
          note_mismatch("Result mismatch", want, got);
        end
      end
    end
  end

  // The receiver stalls in runs of random length, holds off completely on request, or stays ready under rx_free.
  initial begin
    result_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HoldCycles;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else if (rx_free) begin
        result_if.ready <= 1'b1;
      end else begin
        if (run_left <= 0) begin
          rx_on    = !rx_on;
          run_left = rx_on ? $urandom_range(1, 12) : $urandom_range(1, 5);
        end
        run_left--;
        result_if.ready <= rx_on;
      end
    end
  end

  task automatic test_empty_queue();
    send_beat(tsq_pkg::ACT_POP, '1);
    send_beat(tsq_pkg::ACT_POP, '0);
  endtask

  task automatic test_order_and_extremes();
    send_beat(tsq_pkg::ACT_PUSH, '0);
    send_beat(tsq_pkg::ACT_PUSH, '1);
    send_beat(tsq_pkg::ACT_PUSH, 32'hAAAA_AAAA);
    send_beat(tsq_pkg::ACT_PUSH, 32'h5555_5555);
    send_beat(tsq_pkg::ACT_PUSH, 32'h8000_0001);
    repeat (5) send_beat(tsq_pkg::ACT_POP, random_word());
    send_beat(tsq_pkg::ACT_POP, '1);
    send_beat(tsq_pkg::ACT_PUSH, 32'h0000_00A1);
    send_beat(tsq_pkg::ACT_POP, '0);
    send_beat(tsq_pkg::ACT_PUSH, 32'h0000_00B2);
    send_beat(tsq_pkg::ACT_PUSH, 32'h0000_00C3);
    send_beat(tsq_pkg::ACT_POP, '0);
    send_beat(tsq_pkg::ACT_PUSH, 32'h0000_00D4);
    repeat (3) send_beat(tsq_pkg::ACT_POP, random_word());
  endtask

  task automatic test_full_stack();
    repeat (tsq_pkg::StackDepth) send_beat(tsq_pkg::ACT_PUSH, random_word());
    send_beat(tsq_pkg::ACT_PUSH, '1);
    send_beat(tsq_pkg::ACT_POP, '0);
    repeat (tsq_pkg::StackDepth) send_beat(tsq_pkg::ACT_PUSH, random_word());
    send_beat(tsq_pkg::ACT_PUSH, '0);
    repeat (2 * tsq_pkg::StackDepth) send_beat(tsq_pkg::ACT_POP, random_word());
  endtask

  task automatic test_random_traffic(input int count, input int push_pct);
    logic act;
    repeat (count) begin
      act = ($urandom_range(99) < push_pct) ? tsq_pkg::ACT_PUSH : tsq_pkg::ACT_POP;
      send_beat(act, random_word());
    end
  endtask

  task automatic test_receiver_hold();
    tx_gaps = 1'b0;
    hold_token++;
    test_random_traffic(40, 60);
    tx_gaps = 1'b1;
  endtask

  initial begin
    rst_ni          = 1'b0;
    item_if.valid   <= 1'b0;
    item_if.action  <= tsq_pkg::ACT_PUSH;
    item_if.data_in <= '0;
    in_depth        = 0;
    out_depth       = 0;
    mismatch_count  = 0;
    tx_gaps         = 1'b1;
    rx_free         = 1'b0;
    burst_left      = 0;
    hold_token      = 0;
    hold_seen       = 0;
    hold_left       = 0;
    run_left        = 0;
    rx_on           = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_queue();
    test_order_and_extremes();
    test_full_stack();
    test_random_traffic(120, 70);
    test_random_traffic(120, 30);
    test_receiver_hold();
    rx_free = 1'b1;
    tx_gaps = 1'b0;
    test_random_traffic(120, 55);
    rx_free = 1'b0;
    tx_gaps = 1'b1;
    test_random_traffic(150, 50);
    test_random_traffic(100, 80);
    test_random_traffic(100, 20);

    item_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

[two_stack_queue.f]
hw/rtl/tsq_pkg.sv
hw/rtl/tsq_if.sv
hw/rtl/tsq_ctrl.sv
hw/rtl/tsq_dpath.sv
hw/rtl/two_stack_queue.sv
tb/tb_two_stack_queue.sv
